/* rtl/infix_expression_evaluator_top_defines.svh */
// ----------------------------------------------------------------------------
// infix expression evaluator assertion macros
// property shorthands used by the port checker
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, off while reset is held
`define IEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define IEE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg
// shared types, constants and helpers of the infix expression evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iee_pkg;

    localparam int DATA_W          = 32;
    localparam int STEP_W          = $clog2(DATA_W);
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BADCHAR  = 2'd3
    } t_status;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    function automatic logic prec(input t_op op);
        return op[1];
    endfunction

    function automatic t_op char_to_op(input logic [7:0] ch);
        t_op op;
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

/* rtl/infix_expression_evaluator_top.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// two-stack infix evaluator, one character per transfer, one result per
// expression
// ----------------------------------------------------------------------------
// A digit, a space or an ignored character leaves the block ready for the
// next character. An operator character pushes the pending number, meets the
// top operator when the operator stack is not empty, and costs one reduction
// per stacked operator of equal or higher precedence before it is stacked; a
// reduction waits on the bit-serial shared arithmetic unit, which adds or
// subtracts in one pass and multiplies or divides in 32 steps. The character
// marked last pushes its number and then drains the whole operator stack by
// the same reductions. The input stalls throughout that work; a finished
// result waits in its own output register while the next expression is
// taken, and the next final character waits until that register is free.
`timescale 1ns / 1ps

module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_value,
    output logic [1:0]        o_status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_LOOP,
        S_GOT_OP,
        S_RD_RHS,
        S_RD_LHS,
        S_WAIT,
        S_OPPUSH,
        S_FIN,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_opd_cnt;
    logic [CNT_W-1:0]  r_opr_cnt;
    logic [DATA_W-1:0] r_acc;
    t_status           r_err;
    logic              r_end;
    t_op               r_new_op;
    t_op               r_top_op;
    logic [DATA_W-1:0] r_rhs;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    t_status           r_o_status;

    logic              in_xfer;
    logic              is_digit;
    logic              is_op;
    logic [DATA_W-1:0] n_acc;
    logic [CNT_W-1:0]  opd_cnt_m1;
    logic [CNT_W-1:0]  opd_cnt_m2;
    logic [CNT_W-1:0]  opr_cnt_m1;
    logic              opd_full;
    logic              opr_full;
    logic              out_free;
    logic              div_zero;

    logic              opd_we;
    logic [ADDR_W-1:0] opd_waddr;
    logic [DATA_W-1:0] opd_wdata;
    logic [ADDR_W-1:0] opd_raddr;
    logic [DATA_W-1:0] opd_rdata;
    logic              opr_we;
    logic [1:0]        opr_rdata;
    t_op               top_op;

    t_alu_req          alu_req;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    assign in_xfer    = i_valid && !o_stall;
    assign is_digit   = i_ch inside {[CH_0:CH_9]};
    assign is_op      = i_ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    assign n_acc      = {r_acc[DATA_W-4:0], 3'b000} + {r_acc[DATA_W-2:0], 1'b0}
                      + {{(DATA_W-4){1'b0}}, i_ch[3:0]};
    assign opd_cnt_m1 = r_opd_cnt - 1'b1;
    assign opd_cnt_m2 = r_opd_cnt - CNT_W'(2);
    assign opr_cnt_m1 = r_opr_cnt - 1'b1;
    assign opd_full   = (r_opd_cnt == CNT_W'(STACK_DEPTH));
    assign opr_full   = (r_opr_cnt == CNT_W'(STACK_DEPTH));
    assign out_free   = !r_o_valid || !i_stall;
    assign div_zero   = (r_top_op == OP_DIV) && (r_rhs == '0);
    assign top_op     = t_op'(opr_rdata);

    always_comb begin
        opd_we    = 1'b0;
        opd_waddr = r_opd_cnt[ADDR_W-1:0];
        opd_wdata = r_acc;
        if (r_state == S_PUSH) begin
            opd_we = !opd_full;
        end else if (r_state == S_WAIT) begin
            opd_we    = alu_done;
            opd_waddr = opd_cnt_m2[ADDR_W-1:0];
            opd_wdata = alu_result;
        end
    end

    always_comb begin
        case (r_state)
            S_RD_RHS: opd_raddr = opd_cnt_m2[ADDR_W-1:0];
            S_FIN:    opd_raddr = '0;
            default:  opd_raddr = opd_cnt_m1[ADDR_W-1:0];
        endcase
    end

    assign opr_we        = (r_state == S_OPPUSH) && !opr_full;
    assign alu_req.start = (r_state == S_RD_LHS) && !div_zero;
    assign alu_req.op    = r_top_op;

    iee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_opd_ram (
        .i_clk   (i_clk),
        .i_we    (opd_we),
        .i_waddr (opd_waddr),
        .i_wdata (opd_wdata),
        .i_raddr (opd_raddr),
        .o_rdata (opd_rdata)
    );

    iee_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_opr_ram (
        .i_clk   (i_clk),
        .i_we    (opr_we),
        .i_waddr (r_opr_cnt[ADDR_W-1:0]),
        .i_wdata (r_new_op),
        .i_raddr (opr_cnt_m1[ADDR_W-1:0]),
        .o_rdata (opr_rdata)
    );

    iee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (opd_rdata),
        .i_rhs    (r_rhs),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_opd_cnt <= '0;
            r_opr_cnt <= '0;
            r_acc     <= '0;
            r_err     <= ST_OK;
            r_end     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_end <= i_last;
                        if (r_err != ST_OK) begin
                            if (i_last) begin
                                r_state <= S_FIN;
                            end
                        end else if (is_digit) begin
                            r_acc <= n_acc;
                            if (i_last) begin
                                r_state <= S_PUSH;
                            end
                        end else if (i_last) begin
                            r_state <= S_PUSH;
                        end else if (i_ch == CH_SPACE) begin
                            r_state <= S_IDLE;
                        end else if (is_op) begin
                            r_new_op <= char_to_op(i_ch);
                            r_state  <= S_PUSH;
                        end else begin
                            r_err <= ST_BADCHAR;
                        end
                    end
                end
                S_PUSH: begin
                    if (opd_full) begin
                        r_err <= ST_OVERFLOW;
                    end else begin
                        r_opd_cnt <= r_opd_cnt + 1'b1;
                    end
                    r_acc   <= '0;
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_err != ST_OK) begin
                        r_state <= r_end ? S_FIN : S_IDLE;
                    end else if (r_opr_cnt == '0) begin
                        r_state <= r_end ? S_FIN : S_OPPUSH;
                    end else begin
                        r_state <= S_GOT_OP;
                    end
                end
                S_GOT_OP: begin
                    if (!r_end && (prec(top_op) < prec(r_new_op))) begin
                        r_state <= S_OPPUSH;
                    end else if (r_opd_cnt < CNT_W'(2)) begin
                        r_opr_cnt <= '0;
                        r_state   <= S_LOOP;
                    end else begin
                        r_top_op <= top_op;
                        r_state  <= S_RD_RHS;
                    end
                end
                S_RD_RHS: begin
                    r_rhs   <= opd_rdata;
                    r_state <= S_RD_LHS;
                end
                S_RD_LHS: begin
                    if (div_zero) begin
                        r_err   <= ST_DIVZERO;
                        r_state <= S_LOOP;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (alu_done) begin
                        r_opd_cnt <= opd_cnt_m1;
                        r_opr_cnt <= opr_cnt_m1;
                        r_state   <= S_LOOP;
                    end
                end
                S_OPPUSH: begin
                    if (opr_full) begin
                        r_err <= ST_OVERFLOW;
                    end else begin
                        r_opr_cnt <= r_opr_cnt + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_o_valid  <= 1'b1;
                    r_o_status <= r_err;
                    r_o_value  <= ((r_err == ST_OK) && (r_opd_cnt != '0)) ? opd_rdata : '0;
                    r_opd_cnt  <= '0;
                    r_opr_cnt  <= '0;
                    r_acc      <= '0;
                    r_err      <= ST_OK;
                    r_end      <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_value  = r_o_value;
    assign o_status = r_o_status;

endmodule

/* rtl/iee_ram.sv */
// ----------------------------------------------------------------------------
// iee_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/iee_alu.sv */
// ----------------------------------------------------------------------------
// iee_alu
// shared arithmetic unit: one adder, used once for add and subtract and
// once per bit for shift-add multiply and restoring signed divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_alu
    import iee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [DATA_W-1:0] i_lhs,
    input  logic [DATA_W-1:0] i_rhs,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    typedef enum logic {
        A_IDLE,
        A_RUN
    } t_alu_state;

    t_alu_state        r_state;
    t_op               r_op;
    logic              r_neg;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_result;

    logic [DATA_W:0]   add_x;
    logic [DATA_W:0]   add_y;
    logic              add_sub;
    logic [DATA_W+1:0] add_sum;
    logic              add_carry;
    logic [DATA_W:0]   div_shift;
    logic [DATA_W-1:0] lhs_abs;
    logic [DATA_W-1:0] rhs_abs;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] n_q;
    logic [DATA_W-1:0] quot;

    assign div_shift = {r_acc, r_q[DATA_W-1]};
    assign lhs_abs   = i_lhs[DATA_W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign rhs_abs   = i_rhs[DATA_W-1] ? (~i_rhs + 1'b1) : i_rhs;

    always_comb begin
        if (r_state == A_IDLE) begin
            add_x   = {1'b0, i_lhs};
            add_y   = {1'b0, i_rhs};
            add_sub = (i_req.op == OP_SUB);
        end else if (r_op == OP_MUL) begin
            add_x   = {1'b0, r_acc};
            add_y   = {1'b0, r_b};
            add_sub = 1'b0;
        end else begin
            add_x   = div_shift;
            add_y   = {1'b0, r_b};
            add_sub = 1'b1;
        end
    end

    assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + {{(DATA_W+1){1'b0}}, add_sub};
    assign add_carry = add_sum[DATA_W+1];

    always_comb begin
        if (r_op == OP_MUL) begin
            n_acc = r_q[0] ? add_sum[DATA_W-1:0] : r_acc;
            n_q   = {1'b0, r_q[DATA_W-1:1]};
        end else begin
            n_acc = add_carry ? add_sum[DATA_W-1:0] : div_shift[DATA_W-1:0];
            n_q   = {r_q[DATA_W-2:0], add_carry};
        end
        quot = r_neg ? (~n_q + 1'b1) : n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_acc <= '0;
                        r_cnt <= '0;
                        case (i_req.op)
                            OP_ADD, OP_SUB: begin
                                r_result <= add_sum[DATA_W-1:0];
                                r_done   <= 1'b1;
                            end
                            OP_MUL: begin
                                r_b     <= i_rhs;
                                r_q     <= i_lhs;
                                r_state <= A_RUN;
                            end
                            default: begin
                                r_b     <= rhs_abs;
                                r_q     <= lhs_abs;
                                r_neg   <= i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1];
                                r_state <= A_RUN;
                            end
                        endcase
                    end
                end
                A_RUN: begin
                    r_acc <= n_acc;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_op == OP_MUL) begin
                        r_b <= {r_b[DATA_W-2:0], 1'b0};
                    end
                    if (r_cnt == STEP_W'(DATA_W - 1)) begin
                        r_result <= (r_op == OP_MUL) ? n_acc : quot;
                        r_done   <= 1'b1;
                        r_state  <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/iee_checker.sv */
// ----------------------------------------------------------------------------
// iee_checker
// port-level checks of the infix expression evaluator, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_expression_evaluator_top_defines.svh"

module iee_checker
    import iee_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_last,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_value,
    input logic [1:0]        o_status
);

    // an errored expression reports a zero value
    `IEE_ASSERT_IMP(a_err_value_zero, o_valid && (o_status != ST_OK), o_value == '0, "error result with nonzero value")

    // the final character of an expression always starts the result work
    `IEE_ASSERT_NXT(a_last_busy, i_valid && !o_stall && i_last, o_stall, "not busy after final transfer")

    // a result only appears after the block was busy finishing an expression
    `IEE_ASSERT_IMP(a_result_after_work, $rose(o_valid), $past(o_stall), "result without busy period")

    // a stalled result holds
    `IEE_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_status), "stalled result changed")

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (.*);
